/* design/tcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants
// Payload words, controller commands and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tcf_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } tcf_in_t;

  typedef struct packed {
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
    logic signed [31:0] vertical_accel;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] yaw_rate;
  } tcf_out_t;

  localparam int AtanEntries = 24;
  localparam int IdxW        = 5;
  localparam int CfgIdxW     = 8;

  localparam logic [CfgIdxW-1:0] REG_GYRO_GAIN     = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_ACCEL_GAIN    = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_BLEND_ALPHA   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD = 8'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ITER, OP_ROLL_END, OP_PITCH_INIT, OP_PITCH_END,
    OP_RATE_GY, OP_RATE_GZ, OP_RATE_AZ, OP_INTEG_P, OP_INTEG_R,
    OP_BLEND_P1, OP_BLEND_P2, OP_BLEND_R1, OP_BLEND_R2, OP_FINISH
  } tcf_op_t;

  typedef struct packed {
    tcf_op_t         op;
    logic [IdxW-1:0] idx;
  } tcf_cmd_t;

  function automatic logic [15:0] atan_q16(input logic [IdxW-1:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/tcf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_datapath: CORDIC, shared multiplier and filter state
// Executes one command per cycle; holds config registers and result word.
// ----------------------------------------------------------------------------
module tcf_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tcf_pkg::tcf_cmd_t        cmd,
  input  tcf_pkg::tcf_in_t         in_data,
  input  logic                     cfg_we,
  input  logic [tcf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]              cfg_data,
  output tcf_pkg::tcf_out_t        out_data
);
  import tcf_pkg::*;

  localparam logic signed [67:0] Half16 = 68'sd32768;
  localparam logic signed [67:0] Half32 = 68'sd2147483648;
  localparam logic signed [31:0] PiQ16  = 32'sd205887;
  localparam logic [16:0]        One17  = 17'd65536;

  logic [31:0] gyro_gain_r, accel_gain_r, sample_period_r;
  logic [16:0] blend_alpha_r;

  tcf_in_t            smp_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic               zero_r;
  logic signed [67:0] prod_r, acc_r;
  logic signed [31:0] tilt_roll_r, tilt_pitch_r;
  logic signed [31:0] roll_rate_r, pitch_rate_r, yaw_rate_r, vert_r;
  logic signed [31:0] integ_p_r, integ_r_r, pitch_est_r, roll_est_r;
  tcf_out_t           out_r;

  logic signed [33:0] mul_a, mul_b, dx, dy, ax0, ay0, py0, mag;
  logic signed [67:0] prod_nxt, rnd16, rnd32, blend_sum;
  logic               mul_en;
  logic [16:0]        alpha, alpha_c;
  logic signed [31:0] atan_v;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647)       return 32'sh7fffffff;
    else if (v < -68'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [33:0] ext16(input logic signed [15:0] v);
    return {{18{v[15]}}, v};
  endfunction

  function automatic logic signed [33:0] ext32(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  always_comb begin
    alpha   = (blend_alpha_r > One17) ? One17 : blend_alpha_r;
    alpha_c = One17 - alpha;
    dx      = cy_r >>> cmd.idx;
    dy      = cx_r >>> cmd.idx;
    atan_v  = {16'd0, atan_q16(cmd.idx)};
    ax0     = ext16(in_data.accel_z) <<< 14;
    ay0     = ext16(in_data.accel_y) <<< 14;
    rnd16   = (prod_r + Half16) >>> 16;
    rnd32   = (prod_r + Half32) >>> 32;
    mag     = rnd16[33:0];
    py0     = -(ext16(smp_r.accel_x) <<< 14);
    blend_sum = (acc_r + prod_r + Half16) >>> 16;
    mul_en  = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    case (cmd.op)
      OP_ROLL_END: begin
        mul_a = zero_r ? 34'sd0 : cx_r;
        mul_b = 34'sd39797;
      end
      OP_PITCH_END: begin
        mul_a = ext16(smp_r.gyro_x);
        mul_b = {2'b00, gyro_gain_r};
      end
      OP_RATE_GY: begin
        mul_a = ext16(smp_r.gyro_y);
        mul_b = {2'b00, gyro_gain_r};
      end
      OP_RATE_GZ: begin
        mul_a = ext16(smp_r.gyro_z);
        mul_b = {2'b00, gyro_gain_r};
      end
      OP_RATE_AZ: begin
        mul_a = ext16(smp_r.accel_z);
        mul_b = {2'b00, accel_gain_r};
      end
      OP_INTEG_P: begin
        mul_a = ext32(pitch_rate_r);
        mul_b = {2'b00, sample_period_r};
      end
      OP_INTEG_R: begin
        mul_a = ext32(roll_rate_r);
        mul_b = {2'b00, sample_period_r};
      end
      OP_BLEND_P1: begin
        mul_a = ext32(integ_p_r);
        mul_b = {17'd0, alpha};
      end
      OP_BLEND_P2: begin
        mul_a = ext32(tilt_pitch_r);
        mul_b = {17'd0, alpha_c};
      end
      OP_BLEND_R1: begin
        mul_a = ext32(integ_r_r);
        mul_b = {17'd0, alpha};
      end
      OP_BLEND_R2: begin
        mul_a = ext32(tilt_roll_r);
        mul_b = {17'd0, alpha_c};
      end
      default: mul_en = 1'b0;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_gain_r     <= 32'd4574825;
      accel_gain_r    <= 32'd2097152;
      blend_alpha_r   <= 17'd64225;
      sample_period_r <= 32'd4294967;
      pitch_est_r     <= '0;
      roll_est_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GYRO_GAIN:     gyro_gain_r     <= cfg_data;
          REG_ACCEL_GAIN:    accel_gain_r    <= cfg_data;
          REG_BLEND_ALPHA:   blend_alpha_r   <= cfg_data[16:0];
          REG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
          default: ;
        endcase
      end
      // second blend product lands in prod_r in the cycle after issue
      if (cmd.op == OP_BLEND_R1)
        pitch_est_r <= sat32(blend_sum);
      if (cmd.op == OP_FINISH)
        roll_est_r <= sat32(blend_sum);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (mul_en)
      prod_r <= prod_nxt;
    case (cmd.op)
      OP_LOAD: begin
        smp_r  <= in_data;
        zero_r <= (in_data.accel_y == 16'sd0) && (in_data.accel_z == 16'sd0);
        if (in_data.accel_z < 0) begin
          cx_r <= -ax0;
          cy_r <= -ay0;
          cz_r <= (in_data.accel_y >= 0) ? PiQ16 : -PiQ16;
        end else begin
          cx_r <= ax0;
          cy_r <= ay0;
          cz_r <= '0;
        end
      end
      OP_ITER: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + atan_v;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - atan_v;
        end
      end
      OP_ROLL_END: tilt_roll_r <= zero_r ? 32'sd0 : cz_r;
      OP_PITCH_INIT: begin
        cx_r   <= mag;
        cy_r   <= py0;
        cz_r   <= '0;
        zero_r <= (mag == 34'sd0) && (smp_r.accel_x == 16'sd0);
      end
      OP_PITCH_END: tilt_pitch_r <= zero_r ? 32'sd0 : cz_r;
      OP_RATE_GY:   roll_rate_r  <= sat32(rnd16);
      OP_RATE_GZ:   pitch_rate_r <= sat32(rnd16);
      OP_RATE_AZ:   yaw_rate_r   <= sat32(rnd16);
      OP_INTEG_P:   vert_r       <= sat32(rnd16);
      OP_INTEG_R:   integ_p_r    <= sat32(ext32(pitch_est_r) + rnd32);
      OP_BLEND_P1:  integ_r_r    <= sat32(ext32(roll_est_r) + rnd32);
      // first blend product captured in the cycle after issue
      OP_BLEND_P2:  acc_r        <= prod_r;
      OP_BLEND_R1:  ;
      OP_BLEND_R2:  acc_r        <= prod_r;
      default: ;
    endcase
    if (cmd.op == OP_FINISH) begin
      out_r.pitch_angle    <= pitch_est_r;
      out_r.roll_angle     <= sat32(blend_sum);
      out_r.vertical_accel <= vert_r;
      out_r.pitch_rate     <= pitch_rate_r;
      out_r.yaw_rate       <= yaw_rate_r;
    end
  end

  assign out_data = out_r;

endmodule

/* design/tcf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_ctrl: sequencer
// Steps the datapath through both CORDIC passes and the filter update.
// ----------------------------------------------------------------------------
module tcf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tcf_pkg::tcf_cmd_t cmd
);
  import tcf_pkg::*;

  localparam int NSteps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NSteps - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_ROLL, S_ROLL_END, S_PITCH_INIT, S_PITCH, S_PITCH_END,
    S_RATE_GY, S_RATE_GZ, S_RATE_AZ, S_INTEG_P, S_INTEG_R,
    S_BLEND_P1, S_BLEND_P2, S_BLEND_R1, S_BLEND_R2, S_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            fire;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fire          = !out_valid_r || out_ready;
    cmd.op        = OP_NONE;
    cmd.idx       = idx_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = OP_LOAD;
        idx_nxt   = '0;
        state_nxt = S_ROLL;
      end
      S_ROLL: begin
        cmd.op  = OP_ITER;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LastIdx) state_nxt = S_ROLL_END;
      end
      S_ROLL_END:   begin cmd.op = OP_ROLL_END;   state_nxt = S_PITCH_INIT; end
      S_PITCH_INIT: begin
        cmd.op    = OP_PITCH_INIT;
        idx_nxt   = '0;
        state_nxt = S_PITCH;
      end
      S_PITCH: begin
        cmd.op  = OP_ITER;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LastIdx) state_nxt = S_PITCH_END;
      end
      S_PITCH_END:  begin cmd.op = OP_PITCH_END;  state_nxt = S_RATE_GY;  end
      S_RATE_GY:    begin cmd.op = OP_RATE_GY;    state_nxt = S_RATE_GZ;  end
      S_RATE_GZ:    begin cmd.op = OP_RATE_GZ;    state_nxt = S_RATE_AZ;  end
      S_RATE_AZ:    begin cmd.op = OP_RATE_AZ;    state_nxt = S_INTEG_P;  end
      S_INTEG_P:    begin cmd.op = OP_INTEG_P;    state_nxt = S_INTEG_R;  end
      S_INTEG_R:    begin cmd.op = OP_INTEG_R;    state_nxt = S_BLEND_P1; end
      S_BLEND_P1:   begin cmd.op = OP_BLEND_P1;   state_nxt = S_BLEND_P2; end
      S_BLEND_P2:   begin cmd.op = OP_BLEND_P2;   state_nxt = S_BLEND_R1; end
      S_BLEND_R1:   begin cmd.op = OP_BLEND_R1;   state_nxt = S_BLEND_R2; end
      S_BLEND_R2:   begin cmd.op = OP_BLEND_R2;   state_nxt = S_FINISH;   end
      S_FINISH: if (fire) begin
        cmd.op        = OP_FINISH;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* design/tilt_complementary_filter_unit.sv */
`timescale 1ns / 1ps
// A new word is taken only while idle, once the last is done; the two CORDIC passes share one
// shift-add unit and all scaling and blending goes through one shared multiplier.
// The result register lets the next word enter while the previous result waits.
// Reset (synchronous, rst_n low): config registers to defaults, angle estimates to zero.
// ----------------------------------------------------------------------------
// tilt_complementary_filter_unit: pitch/roll complementary filter
// Accel tilt by CORDIC vectoring, gyro integration and alpha blend.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tcf_pkg::tcf_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tcf_pkg::tcf_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import tcf_pkg::*;

  tcf_cmd_t cmd;

  // config writes always taken; the user must issue them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  tcf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tcf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tilt complementary filter unit
// Drives IMU sample words through the valid/ready input channel, predicts
// each filtered pitch/roll word with a bit-true software filter and compares
// every field of every result in order. Covers register settings, idling
// phases on both sides and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import tcf_pkg::*;

  localparam int CordicSteps = 16;
  localparam int Latency     = 2 * CordicSteps + 14;
  localparam int WatchLimit  = 20000;
  localparam int PiQ16       = 205887;
  localparam int InvGainQ16  = 39797;

  // Arctangent table, Q16 radians.
  localparam longint AtanTab[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tcf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tcf_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  always #10 clk = ~clk;

  tilt_complementary_filter_unit #(.CORDIC_STEPS(CordicSteps)) u_top (.*);

  // Filter state and register shadow for prediction.
  logic [31:0] gyro_gain_q, accel_gain_q, period_q;
  logic [16:0] alpha_q;
  longint      pitch_est, roll_est;

  tcf_out_t expected_words[$];
  int       mismatches = 0;
  int       sent = 0, received = 0;
  int       send_idle_pct = 0, stall_pct = 0;
  bit       hold_off = 1'b0;
  int       quiet_cycles = 0;

  function automatic longint shr_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint vector_angle(longint y, longint x, output longint mag);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? PiQ16 : -PiQ16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanTab[i];
      end else begin
        x -= dx; y += dy; z -= AtanTab[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint to_rate(longint cnt, logic [31:0] gain);
    return clamp32(shr_round(cnt * longint'({32'b0, gain}), 16));
  endfunction

  function automatic longint mix_angle(longint ang, longint rate, longint acc);
    longint a, integ;
    a = (alpha_q > 17'd65536) ? 65536 : longint'(alpha_q);
    integ = clamp32(ang + shr_round(rate * longint'({32'b0, period_q}), 32));
    return clamp32(shr_round(a * integ + (65536 - a) * acc, 16));
  endfunction

  function automatic tcf_out_t filter_sample(tcf_in_t s);
    tcf_out_t r;
    longint mag, mag2, tilt_roll, tilt_pitch, roll_r, pitch_r;
    tilt_roll  = vector_angle(longint'(s.accel_y) * 16384, longint'(s.accel_z) * 16384, mag);
    mag        = shr_round(mag * InvGainQ16, 16);
    tilt_pitch = vector_angle(-longint'(s.accel_x) * 16384, mag, mag2);
    roll_r     = to_rate(s.gyro_x, gyro_gain_q);
    pitch_r    = to_rate(s.gyro_y, gyro_gain_q);
    pitch_est  = mix_angle(pitch_est, pitch_r, tilt_pitch);
    roll_est   = mix_angle(roll_est, roll_r, tilt_roll);
    r.pitch_angle    = pitch_est[31:0];
    r.roll_angle     = roll_est[31:0];
    r.vertical_accel = 32'(to_rate(s.accel_z, accel_gain_q));
    r.pitch_rate     = pitch_r[31:0];
    r.yaw_rate       = 32'(to_rate(s.gyro_z, gyro_gain_q));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on word %0d: %s got %0d want %0d", received, what,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  // Output side: stall at random, or hold off for a long stretch on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Scoreboard: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    tcf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("unexpected result word %0d", received);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.pitch_angle != want.pitch_angle)
          report_mismatch("pitch_angle", out_data.pitch_angle, want.pitch_angle);
        if (out_data.roll_angle != want.roll_angle)
          report_mismatch("roll_angle", out_data.roll_angle, want.roll_angle);
        if (out_data.vertical_accel != want.vertical_accel)
          report_mismatch("vertical_accel", out_data.vertical_accel, want.vertical_accel);
        if (out_data.pitch_rate != want.pitch_rate)
          report_mismatch("pitch_rate", out_data.pitch_rate, want.pitch_rate);
        if (out_data.yaw_rate != want.yaw_rate)
          report_mismatch("yaw_rate", out_data.yaw_rate, want.yaw_rate);
      end
      received++;
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog expired, %0d results outstanding", expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Shadow copy; unknown indexes are dropped by the block too.
    case (idx)
      REG_GYRO_GAIN:     gyro_gain_q  = val;
      REG_ACCEL_GAIN:    accel_gain_q = val;
      REG_BLEND_ALPHA:   alpha_q      = val[16:0];
      REG_SAMPLE_PERIOD: period_q     = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one word; the prediction is queued on acceptance. Valid stays up
  // after the accept so the next word can follow at once; drain() drops it.
  task automatic send_sample(tcf_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(filter_sample(s));
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tcf_in_t random_sample();
    tcf_in_t s;
    if ($urandom_range(9) < 7) begin
      // Plausible board attitude: gravity mostly on z, small x and y gyro rates.
      s.accel_x = 16'($signed($urandom_range(16000)) - 8000);
      s.accel_y = 16'($signed($urandom_range(16000)) - 8000);
      s.accel_z = 16'($signed($urandom_range(20000)) - 4000);
      s.gyro_x  = 16'($signed($urandom_range(4000)) - 2000);
      s.gyro_y  = 16'($signed($urandom_range(4000)) - 2000);
      s.gyro_z  = pick16();
    end else begin
      s = {pick16(), pick16(), pick16(), pick16(), pick16(), pick16()};
    end
    return s;
  endfunction

  // Directed rows: fields, and a reset-state expectation where obvious.
  typedef struct {
    tcf_in_t  s;
    bit       known;
    tcf_out_t r;
  } row_t;

  row_t rows[$];

  initial begin
    int n;
    gyro_gain_q  = 32'd4574825;
    accel_gain_q = 32'd2097152;
    alpha_q      = 17'd64225;
    period_q     = 32'd4294967;
    pitch_est    = 0;
    roll_est     = 0;

    // Zero vector straight after reset: everything stays zero.
    rows.push_back('{'0, 1'b1, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
                     1'b0, '0});
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
                     1'b0, '0});
    // Negative z with y sign both ways: the half-turn pre-rotation.
    rows.push_back('{'{16'sd0, 16'sd100, -16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, -16'sd100, -16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd1}, 1'b0, '0});
    rows.push_back('{'{16'sh8000, 16'sd1, 16'sd0, -16'sd1, 16'sd1, -16'sd1}, 1'b0, '0});
    rows.push_back('{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
                     1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        void'(filter_sample(rows[i].s));
        pitch_est = 0; roll_est = 0;
        in_valid <= 1'b1;
        in_data  <= rows[i].s;
        do @(posedge clk); while (!in_ready);
        expected_words.push_back(rows[i].r);
        sent++;
      end else begin
        send_sample(rows[i].s);
      end
    end
    drain();

    // Register extremes: saturating rates, alpha above one, zero gains.
    write_reg(REG_GYRO_GAIN, 32'hffff_ffff);
    write_reg(REG_ACCEL_GAIN, 32'h0);
    write_reg(REG_BLEND_ALPHA, 32'hffff_ffff);
    write_reg(REG_SAMPLE_PERIOD, 32'hffff_ffff);
    write_reg(8'd200, 32'h1234_5678);
    for (int i = 0; i < 12; i++) send_sample(i < 2 ? rows[2 + i].s : random_sample());
    drain();
    write_reg(REG_GYRO_GAIN, 32'h0);
    write_reg(REG_ACCEL_GAIN, 32'hffff_ffff);
    write_reg(REG_BLEND_ALPHA, 32'h0);
    write_reg(REG_SAMPLE_PERIOD, 32'h0);
    for (int i = 0; i < 12; i++) send_sample(i < 2 ? rows[2 + i].s : random_sample());
    drain();

    // Random phases, each with its own settings and idling mix.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_GYRO_GAIN, (ph == 4) ? 32'd4574825 : $urandom);
      write_reg(REG_ACCEL_GAIN, $urandom);
      write_reg(REG_BLEND_ALPHA, $urandom_range(65536 + 10));
      write_reg(REG_SAMPLE_PERIOD, (ph % 2) ? $urandom : $urandom_range(100000000));
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        3: begin send_idle_pct = 22; stall_pct = 22; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      n = 100;
      if (ph == 4) begin
        // Long output hold-off while words keep coming, so input backs up.
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < n; i++) send_sample(random_sample());
      drain();
    end

    $display("covered %0d words in, %0d results out, register extremes and idle mixes",
             sent, received);
    $display("including alpha above one, zero vectors and a long output stall");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tcf_pkg.sv
design/tcf_datapath.sv
design/tcf_ctrl.sv
design/tilt_complementary_filter_unit.sv
test/testbench.sv
